// ----- rtl/core/ucc_pkg.sv -----
// ----------------------------------------------------------------------------
// Upload checker package
// Shared codes, item and result types and the byte-wide CRC-32 step.
// ----------------------------------------------------------------------------
`default_nettype none

package ucc_pkg;

  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    FUNC_START = 2'd0,
    FUNC_CHUNK = 2'd1,
    FUNC_DATA  = 2'd2,
    FUNC_END   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_CHUNK = 2'd1,
    OP_END   = 2'd2,
    OP_RSVD  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_BAD_FRAME    = 3'd1,
    ST_NO_SESSION   = 3'd2,
    ST_TOO_LARGE    = 3'd3,
    ST_CRC_MISMATCH = 3'd4,
    ST_BUSY         = 3'd5,
    ST_STORE_ERROR  = 3'd6,
    ST_RSVD         = 3'd7
  } status_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] total_length;
    logic [31:0] expected_crc;
    logic [31:0] chunk_offset;
    logic [15:0] chunk_length;
    logic [7:0]  data_byte;
    logic [7:0]  seq;
    logic        path_ok;
    logic        store_accepts;
  } item_t;

  typedef struct packed {
    logic [1:0]  op_echo;
    logic [2:0]  status;
    logic [7:0]  seq_echo;
    logic [31:0] progress;
    logic        abort_writer;
    logic        commit_request;
  } res_t;

  typedef struct packed {
    logic step;
    logic emit;
  } ctrl_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] v;
    v = c ^ {24'h0, b};
    for (int k = 0; k < 8; k++) begin
      v = (v >> 1) ^ (v[0] ? CRC_POLY : 32'h0);
    end
    return v;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/ucc_in_if.sv -----
// ----------------------------------------------------------------------------
// Upload checker request channel
// Valid/ready channel carrying one request item.
// ----------------------------------------------------------------------------
`default_nettype none

interface ucc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [31:0] total_length;
  logic [31:0] expected_crc;
  logic [31:0] chunk_offset;
  logic [15:0] chunk_length;
  logic [7:0]  data_byte;
  logic [7:0]  seq;
  logic        path_ok;
  logic        store_accepts;

  modport source (
    output valid, func, total_length, expected_crc, chunk_offset, chunk_length,
           data_byte, seq, path_ok, store_accepts,
    input  ready
  );
  modport sink (
    input  valid, func, total_length, expected_crc, chunk_offset, chunk_length,
           data_byte, seq, path_ok, store_accepts,
    output ready
  );
endinterface

`default_nettype wire

// ----- rtl/core/ucc_out_if.sv -----
// ----------------------------------------------------------------------------
// Upload checker response channel
// Valid/ready channel carrying one response item.
// ----------------------------------------------------------------------------
`default_nettype none

interface ucc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op_echo;
  logic [2:0]  status;
  logic [7:0]  seq_echo;
  logic [31:0] progress;
  logic        abort_writer;
  logic        commit_request;

  modport source (
    output valid, op_echo, status, seq_echo, progress, abort_writer, commit_request,
    input  ready
  );
  modport sink (
    input  valid, op_echo, status, seq_echo, progress, abort_writer, commit_request,
    output ready
  );
endinterface

`default_nettype wire

// ----- rtl/core/chunked_upload_crc_checker_unit.sv -----
// ----------------------------------------------------------------------------
// Chunked upload CRC checker
// Path: input register, then session step, then result register for any response.
// Throughput: one item per cycle while the response side keeps up; the
// byte-wide CRC-32 step between input and result registers sets this.
// Reset: synchronous, active low; clears the session, CRC to all ones.
// ----------------------------------------------------------------------------
`default_nettype none

module chunked_upload_crc_checker_unit import ucc_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  ucc_in_if.sink    in_ch,
  ucc_out_if.source out_ch
);

  logic  item_valid;
  item_t item;
  logic  emit;
  res_t  res;
  logic  busy;
  ctrl_t ctrl;

  assign ctrl.step = item_valid && !busy;
  assign ctrl.emit = emit;

  ucc_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .ctrl       (ctrl),
    .item_valid (item_valid),
    .item       (item)
  );

  ucc_session u_session (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (ctrl),
    .item  (item),
    .emit  (emit),
    .res   (res)
  );

  ucc_out_reg u_out_reg (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (ctrl),
    .res    (res),
    .out_ch (out_ch),
    .busy   (busy)
  );

  a_commit_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.commit_request |->
      out_ch.status == ST_OK && out_ch.op_echo == OP_END && !out_ch.abort_writer)
    else $error("commit without clean end");

  a_item_held: assert property (@(posedge clk) disable iff (!rst_n)
    item_valid && !ctrl.step |=> item_valid && $stable(item))
    else $error("pending item lost");

  a_stall_no_step: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !ctrl.step)
    else $error("step while response stalled");

endmodule

`default_nettype wire

// ----- rtl/core/ucc_in_reg.sv -----
// ----------------------------------------------------------------------------
// Upload checker input register
// Captures one request item and holds it until the session stage steps.
// ----------------------------------------------------------------------------
`default_nettype none

module ucc_in_reg import ucc_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  ucc_in_if.sink    in_ch,
  input  wire ctrl_t ctrl,
  output logic      item_valid,
  output item_t     item
);

  logic  valid_r, valid_nxt;
  item_t item_r;
  logic  take;

  assign in_ch.ready = !valid_r || ctrl.step;
  assign take        = in_ch.valid && in_ch.ready;
  assign valid_nxt   = take ? 1'b1 : (ctrl.step ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= '{func: in_ch.func, total_length: in_ch.total_length,
                  expected_crc: in_ch.expected_crc, chunk_offset: in_ch.chunk_offset,
                  chunk_length: in_ch.chunk_length, data_byte: in_ch.data_byte,
                  seq: in_ch.seq, path_ok: in_ch.path_ok,
                  store_accepts: in_ch.store_accepts};
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

`default_nettype wire

// ----- rtl/core/ucc_session.sv -----
// ----------------------------------------------------------------------------
// Upload checker session stage
// Holds the session state, runs the request checks and the CRC update.
// ----------------------------------------------------------------------------
`default_nettype none

module ucc_session import ucc_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire ctrl_t ctrl,
  input  wire item_t item,
  output logic       emit,
  output res_t       res
);

  logic        session_active_r, session_active_nxt;
  logic        data_phase_r, data_phase_nxt;
  logic [31:0] file_length_r, file_length_nxt;
  logic [31:0] target_crc_r, target_crc_nxt;
  logic [31:0] crc_r, crc_nxt;
  logic [31:0] next_offset_r, next_offset_nxt;
  logic [15:0] bytes_left_r, bytes_left_nxt;
  logic [7:0]  pending_seq_r, pending_seq_nxt;

  logic        clr;
  logic        open;
  logic [32:0] chunk_end;
  logic [31:0] offset_inc;
  op_t         op;

  assign chunk_end  = {1'b0, next_offset_r} + {17'h0, item.chunk_length};
  assign offset_inc = next_offset_r + 32'd1;

  always_comb begin
    case (func_t'(item.func))
      FUNC_START: op = OP_START;
      FUNC_CHUNK: op = OP_CHUNK;
      default:    op = OP_END;
    endcase
  end

  always_comb begin
    session_active_nxt = session_active_r;
    data_phase_nxt     = data_phase_r;
    file_length_nxt    = file_length_r;
    target_crc_nxt     = target_crc_r;
    crc_nxt            = crc_r;
    next_offset_nxt    = next_offset_r;
    bytes_left_nxt     = bytes_left_r;
    pending_seq_nxt    = pending_seq_r;
    clr  = 1'b0;
    open = 1'b0;
    emit = 1'b0;
    res  = '{op_echo: op, status: ST_OK, seq_echo: item.seq, progress: 32'h0,
             abort_writer: 1'b0, commit_request: 1'b0};

    if (func_t'(item.func) == FUNC_DATA) begin
      if (data_phase_r) begin
        crc_nxt         = crc_byte(crc_r, item.data_byte);
        next_offset_nxt = offset_inc;
        bytes_left_nxt  = bytes_left_r - 16'd1;
        if (bytes_left_r == 16'd1) begin
          data_phase_nxt = 1'b0;
          emit           = 1'b1;
          res.op_echo    = OP_CHUNK;
          res.seq_echo   = pending_seq_r;
          res.progress   = offset_inc;
        end
      end
    end else if (data_phase_r) begin
      clr              = 1'b1;
      emit             = 1'b1;
      res.status       = ST_BAD_FRAME;
      res.abort_writer = session_active_r;
    end else begin
      emit = 1'b1;
      unique case (func_t'(item.func))
        FUNC_START: begin
          if (!item.path_ok) begin
            res.status = ST_BAD_FRAME;
          end else begin
            clr              = 1'b1;
            res.abort_writer = session_active_r;
            if (!item.store_accepts) begin
              res.status = ST_STORE_ERROR;
            end else begin
              open = 1'b1;
            end
          end
        end
        FUNC_CHUNK: begin
          if (item.chunk_length == 16'h0) begin
            res.status = ST_BAD_FRAME;
          end else if (!session_active_r) begin
            res.status = ST_NO_SESSION;
          end else if (item.chunk_offset != next_offset_r) begin
            clr              = 1'b1;
            res.status       = ST_BAD_FRAME;
            res.progress     = next_offset_r;
            res.abort_writer = 1'b1;
          end else if (chunk_end > {1'b0, file_length_r}) begin
            clr              = 1'b1;
            res.status       = ST_TOO_LARGE;
            res.abort_writer = 1'b1;
          end else if (!item.store_accepts) begin
            clr              = 1'b1;
            res.status       = ST_BUSY;
            res.abort_writer = 1'b1;
          end else begin
            emit            = 1'b0;
            data_phase_nxt  = 1'b1;
            bytes_left_nxt  = item.chunk_length;
            pending_seq_nxt = item.seq;
          end
        end
        default: begin
          if (!session_active_r) begin
            res.status = ST_NO_SESSION;
          end else if (next_offset_r != file_length_r) begin
            clr              = 1'b1;
            res.status       = ST_BAD_FRAME;
            res.abort_writer = 1'b1;
          end else if ((crc_r ^ CRC_INIT) != target_crc_r) begin
            clr              = 1'b1;
            res.status       = ST_CRC_MISMATCH;
            res.abort_writer = 1'b1;
          end else if (!item.store_accepts) begin
            clr              = 1'b1;
            res.status       = ST_BUSY;
            res.abort_writer = 1'b1;
          end else begin
            clr                = 1'b1;
            res.commit_request = 1'b1;
          end
        end
      endcase
    end

    if (clr) begin
      session_active_nxt = 1'b0;
      data_phase_nxt     = 1'b0;
      file_length_nxt    = 32'h0;
      target_crc_nxt     = 32'h0;
      crc_nxt            = CRC_INIT;
      next_offset_nxt    = 32'h0;
      bytes_left_nxt     = 16'h0;
      pending_seq_nxt    = 8'h0;
    end
    if (open) begin
      session_active_nxt = 1'b1;
      file_length_nxt    = item.total_length;
      target_crc_nxt     = item.expected_crc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      session_active_r <= 1'b0;
      data_phase_r     <= 1'b0;
      file_length_r    <= 32'h0;
      target_crc_r     <= 32'h0;
      crc_r            <= CRC_INIT;
      next_offset_r    <= 32'h0;
      bytes_left_r     <= 16'h0;
      pending_seq_r    <= 8'h0;
    end else if (ctrl.step) begin
      session_active_r <= session_active_nxt;
      data_phase_r     <= data_phase_nxt;
      file_length_r    <= file_length_nxt;
      target_crc_r     <= target_crc_nxt;
      crc_r            <= crc_nxt;
      next_offset_r    <= next_offset_nxt;
      bytes_left_r     <= bytes_left_nxt;
      pending_seq_r    <= pending_seq_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/ucc_out_reg.sv -----
// ----------------------------------------------------------------------------
// Upload checker result register
// Holds one response item until the downstream side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module ucc_out_reg import ucc_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire ctrl_t ctrl,
  input  wire res_t  res,
  ucc_out_if.source  out_ch,
  output logic       busy
);

  logic valid_r, valid_nxt;
  res_t res_r;
  logic load;

  assign load      = ctrl.step && ctrl.emit;
  assign valid_nxt = load ? 1'b1 : (out_ch.ready ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign busy                  = valid_r && !out_ch.ready;
  assign out_ch.valid          = valid_r;
  assign out_ch.op_echo        = res_r.op_echo;
  assign out_ch.status         = res_r.status;
  assign out_ch.seq_echo       = res_r.seq_echo;
  assign out_ch.progress       = res_r.progress;
  assign out_ch.abort_writer   = res_r.abort_writer;
  assign out_ch.commit_request = res_r.commit_request;

endmodule

`default_nettype wire
